// ===== rtl/rv32_pkg.sv =====
`default_nettype none
package rv32_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam logic [31:0] BOOT_RESET = 32'h8000_0000;

  // Opcodes
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

  // Whole system words
  localparam logic [31:0] INS_ECALL  = 32'h0000_0073;
  localparam logic [31:0] INS_EBREAK = 32'h0010_0073;
  localparam logic [31:0] INS_MRET   = 32'h3020_0073;

  // funct7 codes
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MUL  = 7'h01;

  // funct3 codes
  localparam logic [2:0] F3_CSRRW = 3'd1;
  localparam logic [2:0] F3_CSRRS = 3'd2;
  localparam logic [2:0] F3_SLL   = 3'd1;
  localparam logic [2:0] F3_SR    = 3'd5;
  localparam logic [2:0] F3_ADD   = 3'd0;
  localparam logic [2:0] F3_LB    = 3'd0;
  localparam logic [2:0] F3_LH    = 3'd1;
  localparam logic [2:0] F3_LW    = 3'd2;
  localparam logic [2:0] F3_LBU   = 3'd4;
  localparam logic [2:0] F3_LHU   = 3'd5;
  localparam logic [2:0] F3_SB    = 3'd0;
  localparam logic [2:0] F3_SH    = 3'd1;
  localparam logic [2:0] F3_BEQ   = 3'd0;
  localparam logic [2:0] F3_BNE   = 3'd1;
  localparam logic [2:0] F3_BLT   = 3'd4;
  localparam logic [2:0] F3_BGE   = 3'd5;
  localparam logic [2:0] F3_BLTU  = 3'd6;
  localparam logic [2:0] F3_BGEU  = 3'd7;
  localparam logic [2:0] F3_MUL   = 3'd0;
  localparam logic [2:0] F3_MULH  = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_DIV   = 3'd4;
  localparam logic [2:0] F3_REM   = 3'd6;

  // CSR numbers
  localparam logic [11:0] CSR_MTVEC    = 12'h305;
  localparam logic [11:0] CSR_MSTATUS  = 12'h300;
  localparam logic [11:0] CSR_MEPC     = 12'h341;
  localparam logic [11:0] CSR_MCAUSE   = 12'h342;
  localparam logic [11:0] CSR_SATP     = 12'h180;
  localparam logic [11:0] CSR_MSCRATCH = 12'h340;

  localparam logic [31:0] MIE_BIT     = 32'h08;
  localparam logic [31:0] MPIE_BIT    = 32'h80;
  localparam logic [31:0] CAUSE_ECALL = 32'd11;
  localparam logic [4:0]  REG_A0      = 5'd10;

  // Result actions
  localparam logic [2:0] ACT_RETIRE = 3'd0;
  localparam logic [2:0] ACT_LOAD   = 3'd1;
  localparam logic [2:0] ACT_STORE  = 3'd2;
  localparam logic [2:0] ACT_HALT   = 3'd3;
  localparam logic [2:0] ACT_ILLEGAL = 3'd4;
  localparam logic [2:0] ACT_ECALL  = 3'd5;

  typedef struct packed {
    logic       start;
    logic [2:0] funct3;
    logic [31:0] op_a;
    logic [31:0] op_b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } md_rsp_t;

  function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                      input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    case (f3)
      3'd0:    r = alt ? a - b : a + b;
      3'd1:    r = a << b[4:0];
      3'd2:    r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      3'd3:    r = (a < b) ? 32'd1 : 32'd0;
      3'd4:    r = a ^ b;
      3'd5:    r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6:    r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rv32_if.sv =====
`default_nettype none
interface rv32_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] instruction;
  logic [31:0] load_data;
  modport source (output valid, req_type, instruction, load_data, input ready);
  modport sink   (input valid, req_type, instruction, load_data, output ready);
endinterface

interface rv32_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] mem_addr;
  logic [1:0]  mem_size;
  logic [31:0] store_data;
  logic [31:0] next_pc;
  logic [31:0] halt_value;
  modport source (output valid, action, mem_addr, mem_size, store_data, next_pc,
                  halt_value, input ready);
  modport sink   (input valid, action, mem_addr, mem_size, store_data, next_pc,
                  halt_value, output ready);
endinterface

interface rv32_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] boot_address;
  modport source (output valid, boot_address, input ready);
  modport sink   (input valid, boot_address, output ready);
endinterface
`default_nettype wire

// ===== rtl/rv32_ram.sv =====
`default_nettype none
module rv32_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rv32_muldiv.sv =====
`default_nettype none
module rv32_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  rv32_pkg::md_req_t req,
  output rv32_pkg::md_rsp_t rsp
);

  logic        mul_pend_r;
  logic        div_busy_r;
  logic        div_fin_r;
  logic [4:0]  cnt_r;
  logic [2:0]  f3_r;
  logic [63:0] prod_r;
  logic [31:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [31:0] dvd_r;
  logic        neg_q_r;
  logic        neg_r_r;
  logic        dz_r;

  logic        sgn_a;
  logic        sgn_b;
  logic        div_sgn;
  logic [32:0] ext_a;
  logic [32:0] ext_b;
  logic [65:0] prod_full;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic [31:0] q_fix;
  logic [31:0] r_fix;

  // Operand signs per funct3
  always_comb begin
    sgn_a     = (req.funct3 == rv32_pkg::F3_MULH) || (req.funct3 == rv32_pkg::F3_MULHSU);
    sgn_b     = (req.funct3 == rv32_pkg::F3_MULH);
    div_sgn   = (req.funct3 == rv32_pkg::F3_DIV) || (req.funct3 == rv32_pkg::F3_REM);
    ext_a     = {sgn_a & req.op_a[31], req.op_a};
    ext_b     = {sgn_b & req.op_b[31], req.op_b};
    prod_full = 66'($signed(ext_a) * $signed(ext_b));
    rem_sh    = {rem_r, quo_r[31]};
    diff      = rem_sh - {1'b0, dvs_r};
  end

  // Multiply in one registered step, divide one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_pend_r <= 1'b0;
      div_busy_r <= 1'b0;
      div_fin_r  <= 1'b0;
      cnt_r      <= '0;
    end else begin
      mul_pend_r <= 1'b0;
      div_fin_r  <= 1'b0;
      if (req.start) begin
        f3_r <= req.funct3;
        if (!req.funct3[2]) begin
          prod_r     <= prod_full[63:0];
          mul_pend_r <= 1'b1;
        end else begin
          div_busy_r <= 1'b1;
          cnt_r      <= 5'd31;
          quo_r      <= (div_sgn && req.op_a[31]) ? 32'(-req.op_a) : req.op_a;
          dvs_r      <= (div_sgn && req.op_b[31]) ? 32'(-req.op_b) : req.op_b;
          rem_r      <= '0;
          dvd_r      <= req.op_a;
          neg_q_r    <= div_sgn && (req.op_a[31] ^ req.op_b[31]);
          neg_r_r    <= div_sgn && req.op_a[31];
          dz_r       <= (req.op_b == 32'd0);
        end
      end else if (div_busy_r) begin
        if (!diff[32]) begin
          rem_r <= diff[31:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh[31:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          div_busy_r <= 1'b0;
          div_fin_r  <= 1'b1;
        end
      end
    end
  end

  // Sign fix and divide-by-zero rules
  always_comb begin
    q_fix = neg_q_r ? 32'(-quo_r) : quo_r;
    r_fix = neg_r_r ? 32'(-rem_r) : rem_r;
    rsp.done = mul_pend_r | div_fin_r;
    if (!f3_r[2]) begin
      rsp.result = (f3_r == rv32_pkg::F3_MUL) ? prod_r[31:0] : prod_r[63:32];
    end else if (!f3_r[1]) begin
      rsp.result = dz_r ? 32'hFFFF_FFFF : q_fix;
    end else begin
      rsp.result = dz_r ? dvd_r : r_fix;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rv32im_instruction_executor.sv =====
`default_nettype none
// Steps: register file read, execute, commit. A load reply skips the read and execute;
// a multiply or divide then waits for the muldiv unit, which divides 1 bit per cycle.
// Throughput: one item at a time; a new item is taken only once the last one commits.
// A finished result waits in the output register.
// Reset: synchronous active-low rst_n; pc = 0x80000000, registers read as zero via
// per-entry valid bits, CSRs zero, no load pending.
module rv32im_instruction_executor #(
  parameter int unsigned REGISTER_COUNT = rv32_pkg::REG_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  rv32_in_if.sink     in_ch,
  rv32_out_if.source  out_ch,
  rv32_cfg_if.sink    cfg_ch
);

  localparam int unsigned AW = $clog2(REGISTER_COUNT);
  localparam logic [5:0]  RC_W = 6'(REGISTER_COUNT);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MD   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]  state_r;
  logic [31:0] pc_r;
  logic [31:0] mtvec_r, mstatus_r, mepc_r, mcause_r, satp_r, mscratch_r;
  logic [8:0]  pend_r;
  logic [REGISTER_COUNT-1:0] vld_r;

  logic [31:0] ins_r;
  logic [4:0]  ra_r, rb_r;

  // Execute results held until commit
  logic [2:0]  act_r;
  logic [31:0] addr_r, sdata_r, npc_r, halt_r, wbv_r, csr_new_r;
  logic [1:0]  size_r;
  logic        wbe_r, csr_we_r, ecall_r, mret_r;
  logic [4:0]  wbi_r;
  logic [11:0] csr_sel_r;
  logic [8:0]  pend_nxt_r;

  // Output register
  logic        out_valid_r;
  logic [2:0]  o_act_r;
  logic [31:0] o_addr_r, o_sdata_r, o_npc_r, o_halt_r;
  logic [1:0]  o_size_r;

  logic [31:0] rdata_a, rdata_b;
  logic        rf_we;
  logic        in_acc, cfg_we, commit;
  logic [4:0]  ra_sel;
  rv32_pkg::md_req_t md_req;
  rv32_pkg::md_rsp_t md_rsp;

  // Decode and execute signals
  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs1;
  logic [2:0]  f3;
  logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, csr_old;
  logic        csr_hit, bad, take;
  logic [2:0]  x_act;
  logic [31:0] x_addr, x_sdata, x_npc, x_halt, x_wbv, x_csr_new;
  logic [1:0]  x_size;
  logic        x_wbe, x_csr_we, x_ecall, x_mret, x_md;
  logic [8:0]  x_pend;
  logic [31:0] ld_val;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign commit       = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign ra_sel = (in_ch.instruction == rv32_pkg::INS_EBREAK) ? rv32_pkg::REG_A0
                                                            : in_ch.instruction[19:15];
  assign rf_we  = commit && wbe_r && (wbi_r != 5'd0) && ({1'b0, wbi_r} < RC_W);

  rv32_ram #(.WIDTH(rv32_pkg::XLEN), .DEPTH(REGISTER_COUNT)) u_regs (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (wbi_r[AW-1:0]),
    .wdata   (wbv_r),
    .re      (in_acc && !in_ch.req_type),
    .raddr_a (ra_sel[AW-1:0]),
    .raddr_b (in_ch.instruction[AW+19:20]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  rv32_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  assign md_req.start  = (state_r == S_EXEC) && x_md;
  assign md_req.funct3 = f3;
  assign md_req.op_a   = a;
  assign md_req.op_b   = b;

  // Load data extension for the pending load
  always_comb begin
    case (pend_r[2:0])
      rv32_pkg::F3_LB:  ld_val = {{24{in_ch.load_data[7]}}, in_ch.load_data[7:0]};
      rv32_pkg::F3_LH:  ld_val = {{16{in_ch.load_data[15]}}, in_ch.load_data[15:0]};
      rv32_pkg::F3_LBU: ld_val = {24'd0, in_ch.load_data[7:0]};
      rv32_pkg::F3_LHU: ld_val = {16'd0, in_ch.load_data[15:0]};
      default:          ld_val = in_ch.load_data;
    endcase
  end

  // Decode and execute the latched instruction
  always_comb begin
    opc   = ins_r[6:0];
    rd    = ins_r[11:7];
    f3    = ins_r[14:12];
    rs1   = ins_r[19:15];
    f7    = ins_r[31:25];
    a     = (({1'b0, ra_r} < RC_W) && vld_r[ra_r[AW-1:0]]) ? rdata_a : 32'd0;
    b     = (({1'b0, rb_r} < RC_W) && vld_r[rb_r[AW-1:0]]) ? rdata_b : 32'd0;
    imm_i = {{20{ins_r[31]}}, ins_r[31:20]};
    imm_s = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
    imm_b = {{19{ins_r[31]}}, ins_r[31], ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
    imm_j = {{11{ins_r[31]}}, ins_r[31], ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};

    csr_hit = 1'b1;
    case (ins_r[31:20])
      rv32_pkg::CSR_MTVEC:    csr_old = mtvec_r;
      rv32_pkg::CSR_MSTATUS:  csr_old = mstatus_r;
      rv32_pkg::CSR_MEPC:     csr_old = mepc_r;
      rv32_pkg::CSR_MCAUSE:   csr_old = mcause_r;
      rv32_pkg::CSR_SATP:     csr_old = satp_r;
      rv32_pkg::CSR_MSCRATCH: csr_old = mscratch_r;
      default: begin
        csr_old = 32'd0;
        csr_hit = 1'b0;
      end
    endcase

    bad       = 1'b0;
    take      = 1'b0;
    x_act     = rv32_pkg::ACT_RETIRE;
    x_addr    = 32'd0;
    x_size    = 2'd0;
    x_sdata   = 32'd0;
    x_npc     = pc_r + 32'd4;
    x_halt    = 32'd0;
    x_wbe     = 1'b0;
    x_wbv     = 32'd0;
    x_csr_we  = 1'b0;
    x_csr_new = 32'd0;
    x_ecall   = 1'b0;
    x_mret    = 1'b0;
    x_md      = 1'b0;
    x_pend    = 9'd0;

    case (opc)
      rv32_pkg::OPC_LUI: begin
        x_wbe = 1'b1;
        x_wbv = {ins_r[31:12], 12'd0};
      end
      rv32_pkg::OPC_AUIPC: begin
        x_wbe = 1'b1;
        x_wbv = pc_r + {ins_r[31:12], 12'd0};
      end
      rv32_pkg::OPC_JAL: begin
        x_wbe = 1'b1;
        x_wbv = pc_r + 32'd4;
        x_npc = pc_r + imm_j;
      end
      rv32_pkg::OPC_JALR: begin
        if (f3 != rv32_pkg::F3_ADD) begin
          bad = 1'b1;
        end else begin
          x_wbe = 1'b1;
          x_wbv = pc_r + 32'd4;
          x_npc = (a + imm_i) & ~32'd1;
        end
      end
      rv32_pkg::OPC_BRANCH: begin
        case (f3)
          rv32_pkg::F3_BEQ:  take = (a == b);
          rv32_pkg::F3_BNE:  take = (a != b);
          rv32_pkg::F3_BLT:  take = ($signed(a) < $signed(b));
          rv32_pkg::F3_BGE:  take = ($signed(a) >= $signed(b));
          rv32_pkg::F3_BLTU: take = (a < b);
          rv32_pkg::F3_BGEU: take = (a >= b);
          default:           bad  = 1'b1;
        endcase
        if (take) begin
          x_npc = pc_r + imm_b;
        end
      end
      rv32_pkg::OPC_LOAD: begin
        if (f3 inside {rv32_pkg::F3_LB, rv32_pkg::F3_LH, rv32_pkg::F3_LW,
                       rv32_pkg::F3_LBU, rv32_pkg::F3_LHU}) begin
          x_act  = rv32_pkg::ACT_LOAD;
          x_addr = a + imm_i;
          x_size = f3[1:0];
          x_pend = {1'b1, rd, f3};
        end else begin
          bad = 1'b1;
        end
      end
      rv32_pkg::OPC_STORE: begin
        if (f3 > rv32_pkg::F3_LW) begin
          bad = 1'b1;
        end else begin
          x_act  = rv32_pkg::ACT_STORE;
          x_addr = a + imm_s;
          x_size = f3[1:0];
          x_sdata = (f3 == rv32_pkg::F3_SB) ? {24'd0, b[7:0]} :
                    (f3 == rv32_pkg::F3_SH) ? {16'd0, b[15:0]} : b;
        end
      end
      rv32_pkg::OPC_IMM: begin
        if (f3 == rv32_pkg::F3_SLL && f7 != rv32_pkg::F7_BASE) begin
          bad = 1'b1;
        end else if (f3 == rv32_pkg::F3_SR && f7 != rv32_pkg::F7_BASE &&
                     f7 != rv32_pkg::F7_ALT) begin
          bad = 1'b1;
        end else if (f3 == rv32_pkg::F3_SLL || f3 == rv32_pkg::F3_SR) begin
          x_wbe = 1'b1;
          x_wbv = rv32_pkg::alu(f3, f7 == rv32_pkg::F7_ALT, a, {27'd0, ins_r[24:20]});
        end else begin
          x_wbe = 1'b1;
          x_wbv = rv32_pkg::alu(f3, 1'b0, a, imm_i);
        end
      end
      rv32_pkg::OPC_OP: begin
        if (f7 == rv32_pkg::F7_MUL) begin
          x_wbe = 1'b1;
          x_md  = 1'b1;
        end else if (f7 == rv32_pkg::F7_BASE) begin
          x_wbe = 1'b1;
          x_wbv = rv32_pkg::alu(f3, 1'b0, a, b);
        end else if (f7 == rv32_pkg::F7_ALT &&
                     (f3 == rv32_pkg::F3_ADD || f3 == rv32_pkg::F3_SR)) begin
          x_wbe = 1'b1;
          x_wbv = rv32_pkg::alu(f3, 1'b1, a, b);
        end else begin
          bad = 1'b1;
        end
      end
      rv32_pkg::OPC_SYSTEM: begin
        if (f3 == rv32_pkg::F3_CSRRW || f3 == rv32_pkg::F3_CSRRS) begin
          if (!csr_hit) begin
            bad = 1'b1;
          end else begin
            x_wbe     = 1'b1;
            x_wbv     = csr_old;
            x_csr_we  = (f3 == rv32_pkg::F3_CSRRW) || (rs1 != 5'd0);
            x_csr_new = (f3 == rv32_pkg::F3_CSRRW) ? a : (csr_old | a);
          end
        end else if (ins_r == rv32_pkg::INS_ECALL) begin
          x_ecall = 1'b1;
          x_act   = rv32_pkg::ACT_ECALL;
          x_npc   = mtvec_r & ~32'd3;
        end else if (ins_r == rv32_pkg::INS_EBREAK) begin
          x_act  = rv32_pkg::ACT_HALT;
          x_halt = a;
          x_npc  = pc_r;
        end else if (ins_r == rv32_pkg::INS_MRET) begin
          x_mret = 1'b1;
          x_npc  = mepc_r;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase

    // Drop every effect of an illegal instruction
    if (bad) begin
      x_act    = rv32_pkg::ACT_ILLEGAL;
      x_addr   = 32'd0;
      x_size   = 2'd0;
      x_sdata  = 32'd0;
      x_halt   = 32'd0;
      x_npc    = pc_r;
      x_wbe    = 1'b0;
      x_csr_we = 1'b0;
      x_ecall  = 1'b0;
      x_mret   = 1'b0;
      x_md     = 1'b0;
      x_pend   = 9'd0;
    end
  end

  // Sequencer: accept, execute, wait for the multiply/divide unit, commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (!in_ch.req_type) begin
              state_r <= S_EXEC;
            end else if (pend_r[8]) begin
              state_r <= S_DONE;
            end
          end
        end
        S_EXEC: state_r <= x_md ? S_MD : S_DONE;
        S_MD: begin
          if (md_rsp.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Capture the item and the execute results
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      ins_r <= in_ch.instruction;
      ra_r  <= ra_sel;
      rb_r  <= in_ch.instruction[24:20];
      if (in_ch.req_type) begin
        act_r      <= rv32_pkg::ACT_RETIRE;
        addr_r     <= 32'd0;
        size_r     <= 2'd0;
        sdata_r    <= 32'd0;
        halt_r     <= 32'd0;
        npc_r      <= pc_r;
        wbe_r      <= 1'b1;
        wbi_r      <= pend_r[7:3];
        wbv_r      <= ld_val;
        csr_we_r   <= 1'b0;
        ecall_r    <= 1'b0;
        mret_r     <= 1'b0;
        pend_nxt_r <= 9'd0;
      end
    end else if (state_r == S_EXEC) begin
      act_r      <= x_act;
      addr_r     <= x_addr;
      size_r     <= x_size;
      sdata_r    <= x_sdata;
      halt_r     <= x_halt;
      npc_r      <= x_npc;
      wbe_r      <= x_wbe;
      wbi_r      <= rd;
      wbv_r      <= x_wbv;
      csr_we_r   <= x_csr_we;
      csr_sel_r  <= ins_r[31:20];
      csr_new_r  <= x_csr_new;
      ecall_r    <= x_ecall;
      mret_r     <= x_mret;
      pend_nxt_r <= x_pend;
    end else if (state_r == S_MD && md_rsp.done) begin
      wbv_r <= md_rsp.result;
    end
  end

  // Commit architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= rv32_pkg::BOOT_RESET;
      mtvec_r    <= '0;
      mstatus_r  <= '0;
      mepc_r     <= '0;
      mcause_r   <= '0;
      satp_r     <= '0;
      mscratch_r <= '0;
      pend_r     <= '0;
      vld_r      <= '0;
    end else begin
      if (commit) begin
        if (!cfg_we) begin
          pc_r <= npc_r;
        end
        pend_r <= pend_nxt_r;
        if (rf_we) begin
          vld_r[wbi_r[AW-1:0]] <= 1'b1;
        end
        if (csr_we_r) begin
          case (csr_sel_r)
            rv32_pkg::CSR_MTVEC:    mtvec_r    <= csr_new_r;
            rv32_pkg::CSR_MSTATUS:  mstatus_r  <= csr_new_r;
            rv32_pkg::CSR_MEPC:     mepc_r     <= csr_new_r;
            rv32_pkg::CSR_MCAUSE:   mcause_r   <= csr_new_r;
            rv32_pkg::CSR_SATP:     satp_r     <= csr_new_r;
            rv32_pkg::CSR_MSCRATCH: mscratch_r <= csr_new_r;
            default: ;
          endcase
        end
        if (ecall_r) begin
          mepc_r    <= pc_r;
          mcause_r  <= rv32_pkg::CAUSE_ECALL;
          mstatus_r <= (mstatus_r & ~(rv32_pkg::MIE_BIT | rv32_pkg::MPIE_BIT)) |
                       ((mstatus_r & rv32_pkg::MIE_BIT) != 32'd0 ? rv32_pkg::MPIE_BIT
                                                                 : 32'd0);
        end
        if (mret_r) begin
          mstatus_r <= (mstatus_r & ~rv32_pkg::MIE_BIT) | rv32_pkg::MPIE_BIT |
                       ((mstatus_r & rv32_pkg::MPIE_BIT) != 32'd0 ? rv32_pkg::MIE_BIT
                                                                  : 32'd0);
        end
      end
      // Boot address write moves the pc
      if (cfg_we) begin
        pc_r <= cfg_ch.boot_address;
      end
    end
  end

  // Output register: load on commit, drop on transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      o_act_r   <= act_r;
      o_addr_r  <= addr_r;
      o_size_r  <= size_r;
      o_sdata_r <= sdata_r;
      o_npc_r   <= npc_r;
      o_halt_r  <= halt_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.action     = o_act_r;
  assign out_ch.mem_addr   = o_addr_r;
  assign out_ch.mem_size   = o_size_r;
  assign out_ch.store_data = o_sdata_r;
  assign out_ch.next_pc    = o_npc_r;
  assign out_ch.halt_value = o_halt_r;

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (wbi_r != 5'd0))
    else $error("register x0 written");

  a_exec_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.req_type) |=> (state_r == S_EXEC))
    else $error("instruction not executed after accept");

  a_pc_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !cfg_we) |=> (pc_r == $past(npc_r)))
    else $error("pc does not follow committed next pc");

  a_ecall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && ecall_r) |=> (mcause_r == rv32_pkg::CAUSE_ECALL && out_valid_r))
    else $error("ecall did not set cause");

endmodule
`default_nettype wire
